// ===== design/rsd_pkg.sv =====
package rsd_pkg;

    localparam int PulseWidth = 11;
    localparam int ConvWidth  = 8;
    localparam int ValueWidth = 11;

    // event codes carried on event_kind
    typedef enum logic [3:0] {
        KIND_PULSE    = 4'd0,
        KIND_KEYS     = 4'd1,
        KIND_CONV     = 4'd2,
        KIND_RESET    = 4'd3,
        KIND_ECHO     = 4'd4,
        KIND_IN_OVF   = 4'd5,
        KIND_SER_ERR  = 4'd6,
        KIND_OUT_OVF  = 4'd7,
        KIND_UNKNOWN  = 4'd8
    } event_kind_t;

    // top two bits of a received byte
    localparam logic [1:0] GRP_PULSE_LO = 2'b00;
    localparam logic [1:0] GRP_PULSE_HI = 2'b01;
    localparam logic [1:0] GRP_KEY_CONV = 2'b10;
    localparam logic [1:0] GRP_UPPER    = 2'b11;

    // fixed status bytes
    localparam logic [7:0] BYTE_RESET   = 8'b1101_0000;
    localparam logic [7:0] BYTE_ECHO    = 8'b1101_0001;
    localparam logic [7:0] BYTE_IN_OVF  = 8'b1101_0010;
    localparam logic [7:0] BYTE_SER_ERR = 8'b1101_0011;
    localparam logic [7:0] BYTE_OUT_OVF = 8'b1101_0100;

    // channel selects and accumulators
    typedef struct packed {
        logic                                pulse_select;
        logic [1:0][PulseWidth-1:0]          pulse_accum;
        logic                                conv_select;
        logic [1:0][ConvWidth-1:0]           conv_accum;
    } dec_state_t;

    // one decoded event
    typedef struct packed {
        logic                    emit;
        event_kind_t             kind;
        logic                    chan;
        logic [ValueWidth-1:0]   value;
    } dec_event_t;

endpackage

// ===== design/rsd_decode.sv =====
module rsd_decode
    import rsd_pkg::*;
(
    input  logic [7:0]  byte_in,
    input  dec_state_t  state_cur,
    output dec_state_t  state_next,
    output dec_event_t  evt
);

    logic [PulseWidth-1:0] pulse_or;
    logic [ConvWidth-1:0]  conv_or;

    // high parts merged into the currently selected accumulator
    assign pulse_or = state_cur.pulse_accum[state_cur.pulse_select]
                    | {byte_in[5:0], 5'b0};
    assign conv_or  = state_cur.conv_accum[state_cur.conv_select]
                    | {byte_in[3:0], 4'b0};

    // byte classification and state update
    always_comb
    begin
        state_next = state_cur;
        evt.emit   = 1'b1;
        evt.kind   = KIND_UNKNOWN;
        evt.chan   = 1'b0;
        evt.value  = '0;
        unique case (byte_in[7:6])
            GRP_PULSE_LO:
            begin
                // low part of a pulse width: select channel, load bits
                state_next.pulse_select = byte_in[5];
                state_next.pulse_accum[byte_in[5]] = {6'b0, byte_in[4:0]};
                evt.emit = 1'b0;
            end
            GRP_PULSE_HI:
            begin
                state_next.pulse_accum[state_cur.pulse_select] = pulse_or;
                evt.kind  = KIND_PULSE;
                evt.chan  = state_cur.pulse_select;
                evt.value = pulse_or;
            end
            GRP_KEY_CONV:
            begin
                if (!byte_in[5])
                begin
                    evt.kind  = KIND_KEYS;
                    evt.value = {6'b0, byte_in[4:0]};
                end
                else
                begin
                    // low part of a converter value
                    state_next.conv_select = byte_in[4];
                    state_next.conv_accum[byte_in[4]] = {4'b0, byte_in[3:0]};
                    evt.emit = 1'b0;
                end
            end
            GRP_UPPER:
            begin
                if (byte_in[5:4] == 2'b00)
                begin
                    state_next.conv_accum[state_cur.conv_select] = conv_or;
                    evt.kind  = KIND_CONV;
                    evt.chan  = state_cur.conv_select;
                    evt.value = {3'b0, conv_or};
                end
                else
                begin
                    unique case (byte_in)
                        BYTE_RESET:   evt.kind = KIND_RESET;
                        BYTE_ECHO:    evt.kind = KIND_ECHO;
                        BYTE_IN_OVF:  evt.kind = KIND_IN_OVF;
                        BYTE_SER_ERR: evt.kind = KIND_SER_ERR;
                        BYTE_OUT_OVF: evt.kind = KIND_OUT_OVF;
                        default:
                        begin
                            evt.kind  = KIND_UNKNOWN;
                            evt.value = {3'b0, byte_in};
                        end
                    endcase
                end
            end
            default:
            begin
                evt.emit = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/reply_stream_decoder.sv =====
// Decoder for a peripheral controller's reply byte stream. One byte is taken
// per transfer on the input channel and at most one event leaves per byte on
// the output channel; low parts of pulse-width and converter values only
// update the channel accumulators and produce nothing. A byte is captured in
// an input register, decoded from there and its event written to the output
// register. A new byte can be taken every cycle unless in_ready drops, which
// happens only while both the input and output registers are full and the
// output is not being taken.
module reply_stream_decoder
    import rsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             event_kind,
    output logic                   channel,
    output logic [ValueWidth-1:0]  value
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    dec_state_t             state_reg;
    dec_state_t             state_next;
    dec_event_t             evt;
    logic                   out_valid_reg;
    event_kind_t            kind_reg;
    logic                   chan_reg;
    logic [ValueWidth-1:0]  value_reg;
    logic                   out_load;
    logic                   advance;

    rsd_decode u_decode (
        .byte_in    (in_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .evt        (evt)
    );

    // output register free, and the decode stage moves on
    assign out_load = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!evt.emit || out_load);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // channel selects and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= advance && evt.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && evt.emit)
        begin
            kind_reg  <= evt.kind;
            chan_reg  <= evt.chan;
            value_reg <= evt.value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign channel    = chan_reg;
    assign value      = value_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rsd_pkg::*;

    // byte tags made of the two-bit group field and the bits below it
    localparam logic [2:0] KEY_TAG     = 3'b100;
    localparam logic [2:0] CONV_LO_TAG = 3'b101;
    localparam logic [3:0] CONV_HI_TAG = 4'b1100;

    localparam int PHASE_BYTES = 330;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    // one expected event
    typedef struct packed {
        event_kind_t            kind;
        logic                   chan;
        logic [ValueWidth-1:0]  value;
    } reply_event_t;

    // decoder state mirror and queue of events still to come out
    class reply_event_model;
        reply_event_t           queued_events[$];
        logic                   pulse_sel;
        logic [PulseWidth-1:0]  pulse_acc[2];
        logic                   conv_sel;
        logic [ConvWidth-1:0]   conv_acc[2];
        int                     mismatches;
        int                     events_checked;
        int                     kind_seen[16];

        function new();
            pulse_sel = 1'b0;
            pulse_acc[0] = '0;
            pulse_acc[1] = '0;
            conv_sel = 1'b0;
            conv_acc[0] = '0;
            conv_acc[1] = '0;
            mismatches = 0;
            events_checked = 0;
            foreach (kind_seen[i])
                kind_seen[i] = 0;
        endfunction

        function void push_event(event_kind_t kind, logic chan, logic [ValueWidth-1:0] val);
            reply_event_t ev;
            ev.kind = kind;
            ev.chan = chan;
            ev.value = val;
            queued_events.push_back(ev);
        endfunction

        // decode one accepted byte and queue the event it causes, if any
        function void note_byte(logic [7:0] b);
            case (b[7:6])
                GRP_PULSE_LO:
                begin
                    pulse_sel = b[5];
                    pulse_acc[pulse_sel] = {6'b0, b[4:0]};
                end
                GRP_PULSE_HI:
                begin
                    pulse_acc[pulse_sel] = pulse_acc[pulse_sel] | {b[5:0], 5'b0};
                    push_event(KIND_PULSE, pulse_sel, pulse_acc[pulse_sel]);
                end
                GRP_KEY_CONV:
                begin
                    if (b[7:5] == KEY_TAG)
                        push_event(KIND_KEYS, 1'b0, {6'b0, b[4:0]});
                    else
                    begin
                        conv_sel = b[4];
                        conv_acc[conv_sel] = {4'b0, b[3:0]};
                    end
                end
                default:
                begin
                    if (b[7:4] == CONV_HI_TAG)
                    begin
                        conv_acc[conv_sel] = conv_acc[conv_sel] | {b[3:0], 4'b0};
                        push_event(KIND_CONV, conv_sel, {3'b0, conv_acc[conv_sel]});
                    end
                    else if (b >= BYTE_RESET && b <= BYTE_OUT_OVF)
                        push_event(event_kind_t'(KIND_RESET + (b - BYTE_RESET)), 1'b0, '0);
                    else
                        push_event(KIND_UNKNOWN, 1'b0, {3'b0, b});
                end
            endcase
        endfunction

        // compare one output transfer with the oldest queued event
        function void check_event(logic [3:0] kind, logic chan, logic [ValueWidth-1:0] val);
            reply_event_t ev;
            events_checked++;
            kind_seen[kind]++;
            if (queued_events.size() == 0)
            begin
                $error("unexpected event: event_kind %0d, channel %0d, value %0d",
                       kind, chan, val);
                mismatches++;
            end
            else
            begin
                ev = queued_events.pop_front();
                if (kind !== ev.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", ev.kind, kind);
                    mismatches++;
                end
                if (chan !== ev.chan)
                begin
                    $error("channel: expected %0d, got %0d", ev.chan, chan);
                    mismatches++;
                end
                if (val !== ev.value)
                begin
                    $error("value: expected %0d, got %0d", ev.value, val);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             rx_byte = 8'h00;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [3:0]             event_kind;
    logic                   channel;
    logic [ValueWidth-1:0]  value;

    reply_event_model model = new();
    int send_idle = 0;
    int recv_stall = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    reply_stream_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .channel    (channel),
        .value      (value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // output side: check each transfer, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            model.check_event(event_kind, channel, value);
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one byte, with an optional random gap first, until it transfers
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        model.note_byte(b);
        bytes_sent++;
    endtask

    // hold the input idle until every queued event has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (model.queued_events.size() != 0)
            @(posedge clk);
    endtask

    // mostly complete low/high pairs with random content, plus noise
    task automatic send_random_phase(input int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                send_byte({GRP_PULSE_LO, 6'($urandom)});
                send_byte({GRP_PULSE_HI, 6'($urandom)});
                sent += 2;
                if ($urandom_range(4) == 0)
                begin
                    send_byte({GRP_PULSE_HI, 6'($urandom)});
                    sent++;
                end
            end
            else if (pick < 55)
            begin
                send_byte({CONV_LO_TAG, 5'($urandom)});
                send_byte({CONV_HI_TAG, 4'($urandom)});
                sent += 2;
                if ($urandom_range(4) == 0)
                begin
                    send_byte({CONV_HI_TAG, 4'($urandom)});
                    sent++;
                end
            end
            else if (pick < 65)
            begin
                send_byte({KEY_TAG, 5'($urandom)});
                sent++;
            end
            else if (pick < 75)
            begin
                send_byte(BYTE_RESET + 8'($urandom_range(0, 4)));
                sent++;
            end
            else if (pick < 85)
            begin
                send_byte(8'($urandom_range(BYTE_OUT_OVF + 1, 255)));
                sent++;
            end
            else
            begin
                send_byte(8'($urandom));
                sent++;
            end
        end
    endtask

    // high parts before any low part, extremes, repeated high parts,
    // every status byte and some unknown bytes
    logic [7:0] directed_bytes[] = '{
        8'h7F, 8'hCF, 8'h00, 8'h40, 8'h3F, 8'h7F, 8'h55, 8'h20, 8'h41,
        8'h80, 8'h9F, 8'hA0, 8'hC0, 8'hBF, 8'hCF, 8'hC5,
        BYTE_RESET, BYTE_ECHO, BYTE_IN_OVF, BYTE_SER_ERR, BYTE_OUT_OVF,
        8'hD5, 8'hDF, 8'hE0, 8'hFF
    };

    int phase_idle[4]  = '{0, 60, 0, 25};
    int phase_stall[4] = '{0, 0, 60, 25};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            send_idle = phase_idle[p];
            recv_stall = phase_stall[p];
            send_random_phase(PHASE_BYTES);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d bytes sent over four pacing phases, %0d events checked",
                 bytes_sent, model.events_checked);
        $display("pulse %0d, keys %0d, converter %0d, status %0d, unknown %0d",
                 model.kind_seen[KIND_PULSE], model.kind_seen[KIND_KEYS],
                 model.kind_seen[KIND_CONV],
                 model.kind_seen[KIND_RESET] + model.kind_seen[KIND_ECHO]
                 + model.kind_seen[KIND_IN_OVF] + model.kind_seen[KIND_SER_ERR]
                 + model.kind_seen[KIND_OUT_OVF],
                 model.kind_seen[KIND_UNKNOWN]);
        if (model.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
design/rsd_pkg.sv
design/rsd_decode.sv
design/reply_stream_decoder.sv
tb/tb.sv
